// ===== hw/rtl/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// Shared types and constants for the rc frame decoder with motor failsafe.
// ----------------------------------------------------------------------------
package rcfd_pkg;

  // item kinds carried on the input tuser bit
  typedef enum logic [0:0] {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // configuration register indexes (word address bit 2)
  localparam logic [0:0] REG_HEADER  = 1'b0;
  localparam logic [0:0] REG_TIMEOUT = 1'b1;

  // reset values
  localparam logic [7:0]  HEADER_RESET  = 8'hAA;
  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [10:0] SERVO_CENTER  = 11'd1500;

  // frame layout: header, speed, angle, flags, checksum
  localparam logic [2:0] FRAME_LAST = 3'd4;

  // watchdog counter saturation point
  localparam logic [16:0] ELAPSED_MAX = 17'h10000;

  // speed mapping
  localparam logic [7:0] SPEED_MID  = 8'd128;
  localparam logic [7:0] SPEED_CLAMP = 8'd255;
  localparam int MOTOR_FULL  = 999;
  localparam int SPEED_FULL  = 255;
  localparam int MOTOR_SHIFT = 15;
  // ceil(999 * 2^15 / 255): exact floor quotient for magnitudes 0..255
  localparam int MOTOR_RECIP = (MOTOR_FULL * (1 << MOTOR_SHIFT) + SPEED_FULL - 1) / SPEED_FULL;
  localparam int MOTOR_RECIP_W = 17;

  // servo mapping
  localparam logic [7:0] ANGLE_MAX = 8'd180;
  localparam int SERVO_SPAN  = 1000;
  localparam int ANGLE_FULL  = 180;
  localparam int SERVO_BASE  = 1000;
  localparam int SERVO_SHIFT = 11;
  // ceil(1000 * 2^11 / 180): exact floor quotient for angles 0..180
  localparam int SERVO_RECIP = (SERVO_SPAN * (1 << SERVO_SHIFT) + ANGLE_FULL - 1) / ANGLE_FULL;
  localparam int SERVO_RECIP_W = 14;

  // completed frame seen by the decoder
  typedef struct packed {
    logic       ok;
    logic [7:0] speed;
    logic [7:0] angle;
    logic [7:0] flags;
  } frame_evt_t;

  // drive settings derived from one good frame
  typedef struct packed {
    logic        fwd;
    logic        rev;
    logic [9:0]  motor;
    logic [10:0] servo;
  } drive_t;

endpackage

// ===== hw/rtl/rcfd_frame.sv =====
// ----------------------------------------------------------------------------
// rcfd_frame
// Header hunt, frame byte capture and checksum test.
// ----------------------------------------------------------------------------
module rcfd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          header_byte,
  output rcfd_pkg::frame_evt_t evt
);

  logic [2:0] pos_r;
  logic [2:0] pos_nxt;
  logic [7:0] bytes_r [4];
  logic       take;
  logic [7:0] csum;

  // a byte is kept unless we are hunting and it is not the header
  assign take = step && !((pos_r == 3'd0) && (rx_byte != header_byte));
  assign csum = bytes_r[0] ^ bytes_r[1] ^ bytes_r[2] ^ bytes_r[3];

  // position in the frame
  always_comb begin
    pos_nxt = pos_r;
    if (take) begin
      if (pos_r == rcfd_pkg::FRAME_LAST) begin
        pos_nxt = 3'd0;
      end else begin
        pos_nxt = pos_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 3'd0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // frame bytes, no reset needed
  always_ff @(posedge clk) begin
    if (take && (pos_r != rcfd_pkg::FRAME_LAST)) begin
      bytes_r[pos_r[1:0]] <= rx_byte;
    end
  end

  // checksum beat closes the frame
  always_comb begin
    evt.ok    = step && (pos_r == rcfd_pkg::FRAME_LAST) && (csum == rx_byte);
    evt.speed = bytes_r[1];
    evt.angle = bytes_r[2];
    evt.flags = bytes_r[3];
  end

endmodule

// ===== hw/rtl/rcfd_watchdog.sv =====
// ----------------------------------------------------------------------------
// rcfd_watchdog
// Tick counter since the last good frame and one-shot motor stop.
// ----------------------------------------------------------------------------
module rcfd_watchdog (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick,
  input  logic        rearm,
  input  logic [15:0] timeout_ticks,
  output logic        trip
);

  logic [16:0] elapsed_r;
  logic [16:0] elapsed_nxt;
  logic        stopped_r;
  logic        stopped_nxt;
  logic [16:0] elapsed_inc;

  // saturating increment
  assign elapsed_inc = (elapsed_r != rcfd_pkg::ELAPSED_MAX) ? elapsed_r + 17'd1 : elapsed_r;
  assign trip = tick && (elapsed_inc > {1'b0, timeout_ticks}) && !stopped_r;

  always_comb begin
    elapsed_nxt = elapsed_r;
    stopped_nxt = stopped_r;
    if (rearm) begin
      elapsed_nxt = 17'd0;
      stopped_nxt = 1'b0;
    end else if (tick) begin
      elapsed_nxt = elapsed_inc;
      if (trip) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= 17'd0;
      stopped_r <= 1'b0;
    end else begin
      elapsed_r <= elapsed_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== hw/rtl/rcfd_drive_calc.sv =====
// ----------------------------------------------------------------------------
// rcfd_drive_calc
// Maps the speed and angle bytes of a frame to H-bridge bits and compares.
// ----------------------------------------------------------------------------
module rcfd_drive_calc (
  input  logic [7:0]       speed,
  input  logic [7:0]       angle,
  output rcfd_pkg::drive_t drv
);

  localparam int MPROD_W = 8 + rcfd_pkg::MOTOR_RECIP_W;
  localparam int SPROD_W = 8 + rcfd_pkg::SERVO_RECIP_W;

  logic [7:0]         mag;
  logic [7:0]         below;
  logic [7:0]         ang;
  logic [MPROD_W-1:0] mprod;
  logic [SPROD_W-1:0] sprod;

  // (speed - 128) * 2 clamped to +-255, split into direction and magnitude
  assign below = rcfd_pkg::SPEED_MID - speed;
  always_comb begin
    drv.fwd = 1'b0;
    drv.rev = 1'b0;
    mag     = 8'd0;
    if (speed > rcfd_pkg::SPEED_MID) begin
      drv.fwd = 1'b1;
      mag     = {speed[6:0], 1'b0};
    end else if (speed < rcfd_pkg::SPEED_MID) begin
      drv.rev = 1'b1;
      mag     = (speed == 8'd0) ? rcfd_pkg::SPEED_CLAMP : {below[6:0], 1'b0};
    end
  end

  // magnitude * 999 / 255 by reciprocal multiply
  assign mprod     = MPROD_W'(mag) * MPROD_W'(rcfd_pkg::MOTOR_RECIP);
  assign drv.motor = mprod[rcfd_pkg::MOTOR_SHIFT +: 10];

  // 1000 + angle * 1000 / 180, angle clamped
  assign ang       = (angle > rcfd_pkg::ANGLE_MAX) ? rcfd_pkg::ANGLE_MAX : angle;
  assign sprod     = SPROD_W'(ang) * SPROD_W'(rcfd_pkg::SERVO_RECIP);
  assign drv.servo = 11'(rcfd_pkg::SERVO_BASE) + {1'b0, sprod[rcfd_pkg::SERVO_SHIFT +: 10]};

endmodule

// ===== hw/rtl/rc_frame_decoder_with_failsafe_core.sv =====
// ----------------------------------------------------------------------------
// rc_frame_decoder_with_failsafe_core
// Decodes five-byte rc frames into motor and servo settings, with a
// tick-driven watchdog that stops the motor once after a timeout.
// ----------------------------------------------------------------------------
// One beat is taken per cycle while the output is not stalled: each beat passes
// through an input register, combinational decode and arithmetic, and a result
// register. When the result register is full and out_tready is low, a full input
// register holds and in_tready drops.
// Byte beats (in_tuser 0) and tick beats (in_tuser 1) share one stream; at
// most one result leaves per beat. Registers: header_byte at 0x0, timeout_ticks
// at 0x4; write them only while the block is idle.
module rc_frame_decoder_with_failsafe_core (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [0] drive_forward, [1] drive_reverse,
                                  // [11:2] motor_compare, [22:12] servo_compare,
                                  // [30:23] flag_bits, [31] failsafe_trip
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // configuration registers
  logic [7:0]  header_r;
  logic [15:0] timeout_r;
  logic        cfg_wr;

  // input register
  logic                 in_v_r;
  rcfd_pkg::cmd_t       in_cmd_r;
  logic [7:0]           in_byte_r;

  // held state and result register
  logic [10:0] held_servo_r;
  logic [7:0]  held_flags_r;
  logic        out_v_r;
  logic        out_fwd_r;
  logic        out_rev_r;
  logic [9:0]  out_motor_r;
  logic [10:0] out_servo_r;
  logic [7:0]  out_flags_r;
  logic        out_trip_r;

  logic                 out_free;
  logic                 adv;
  logic                 step_byte;
  logic                 step_tick;
  logic                 trip;
  rcfd_pkg::frame_evt_t evt;
  rcfd_pkg::drive_t     drv;

  // config write and read-back
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r  <= rcfd_pkg::HEADER_RESET;
      timeout_r <= rcfd_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rcfd_pkg::REG_HEADER:  header_r  <= cfg_pwdata[7:0];
        rcfd_pkg::REG_TIMEOUT: timeout_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      rcfd_pkg::REG_HEADER:  cfg_prdata = {24'd0, header_r};
      rcfd_pkg::REG_TIMEOUT: cfg_prdata = {16'd0, timeout_r};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  // handshake: the work stage advances whenever the result slot can take it
  assign out_free  = !out_v_r || out_tready;
  assign adv       = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;
  assign step_byte = adv && (in_cmd_r == rcfd_pkg::CMD_BYTE);
  assign step_tick = adv && (in_cmd_r == rcfd_pkg::CMD_TICK);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r  <= rcfd_pkg::cmd_t'(in_tuser[0]);
      in_byte_r <= in_tdata;
    end
  end

  // frame decode, watchdog and drive arithmetic
  rcfd_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step_byte),
    .rx_byte     (in_byte_r),
    .header_byte (header_r),
    .evt         (evt)
  );

  rcfd_watchdog u_watchdog (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (step_tick),
    .rearm         (evt.ok),
    .timeout_ticks (timeout_r),
    .trip          (trip)
  );

  rcfd_drive_calc u_calc (
    .speed (evt.speed),
    .angle (evt.angle),
    .drv   (drv)
  );

  // held servo compare and flags follow each good frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_servo_r <= rcfd_pkg::SERVO_CENTER;
      held_flags_r <= 8'd0;
    end else if (evt.ok) begin
      held_servo_r <= drv.servo;
      held_flags_r <= evt.flags;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= evt.ok || trip;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.ok) begin
      out_fwd_r   <= drv.fwd;
      out_rev_r   <= drv.rev;
      out_motor_r <= drv.motor;
      out_servo_r <= drv.servo;
      out_flags_r <= evt.flags;
      out_trip_r  <= 1'b0;
    end else if (trip) begin
      out_fwd_r   <= 1'b0;
      out_rev_r   <= 1'b0;
      out_motor_r <= 10'd0;
      out_servo_r <= held_servo_r;
      out_flags_r <= held_flags_r;
      out_trip_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_trip_r, out_flags_r, out_servo_r, out_motor_r, out_rev_r, out_fwd_r};

  // the h-bridge is never driven both ways
  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_fwd_r && out_rev_r))
    else $error("both h-bridge inputs set");

  // a watchdog stop always carries a stopped motor
  a_trip_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_trip_r) |-> (out_motor_r == 10'd0 && !out_fwd_r && !out_rev_r))
    else $error("failsafe result with motor running");

  // compares stay in their ranges
  a_compare_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_motor_r <= 10'd999 && out_servo_r >= 11'd1000 &&
                 out_servo_r <= 11'd2000))
    else $error("compare value out of range");

  // a result is only produced by a beat leaving the work stage
  a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !$past(out_v_r)) |-> $past(in_v_r))
    else $error("result without a beat");

endmodule
